### design/gdad_pkg.sv
`timescale 1ns / 1ps

package gdad_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 16;
  localparam int unsigned OffW   = 9;

  localparam logic [YearW-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [OffW-1:0]   LEAP_CYCLE  = 9'd400;
  localparam logic [MonthW-1:0] MONTH_LAST  = 4'd12;
  localparam logic [DayW-1:0]   DAY_LAST    = 5'd31;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // Leap year from the two low bits of the year and the year modulo 400.
  // A year divisible by 4 is a leap year unless it is a century that is not
  // a multiple of 400.
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [OffW-1:0] r400);
    logic century;
    century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return (y_lo == 2'd0) && !century;
  endfunction

  function automatic logic [OffW-1:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] n;
    case (m)
      4'd2:                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### design/gdad_alu.sv
`timescale 1ns / 1ps

module gdad_alu (
  input  gdad_pkg::alu_op_e                 op_i,
  input  logic [gdad_pkg::CountW-1:0]       a_i,
  input  logic [gdad_pkg::CountW-1:0]       b_i,
  output logic [gdad_pkg::CountW-1:0]       res_o,
  output logic                              borrow_o,
  output logic                              zero_o
);

  logic [gdad_pkg::CountW:0] full;

  always_comb begin
    if (op_i == gdad_pkg::ALU_SUB) begin
      full = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      full = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign res_o    = full[gdad_pkg::CountW-1:0];
  assign borrow_o = full[gdad_pkg::CountW];
  assign zero_o   = (full[gdad_pkg::CountW-1:0] == '0);

endmodule

### design/gregorian_date_add_days_unit.sv
`timescale 1ns / 1ps

// Adds a day count to a Gregorian date. A setup first reduces the year modulo
// 400, the day of the year is summed one month per cycle, then whole years are
// stepped off one per cycle and the remainder is split into months, again one
// per cycle. Every step runs through one shared 16-bit add/subtract unit. The
// unit takes a new word only when idle; a finished result waits in the output
// register while the next word is accepted. Out-of-range starting fields are
// clamped, and a result past year 9999 reads as 31 December 9999 with
// year_overflow_o set.
module gregorian_date_add_days_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [gdad_pkg::DayW-1:0]           start_day_i,
  input  logic [gdad_pkg::MonthW-1:0]         start_month_i,
  input  logic [gdad_pkg::YearW-1:0]          start_year_i,
  input  logic [gdad_pkg::CountW-1:0]         days_to_add_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gdad_pkg::DayW-1:0]           end_day_o,
  output logic [gdad_pkg::MonthW-1:0]         end_month_o,
  output logic [gdad_pkg::YearW-1:0]          end_year_o,
  output logic                                year_overflow_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_CLAMP = 3'd2;
  localparam logic [2:0] S_DOY   = 3'd3;
  localparam logic [2:0] S_REM   = 3'd4;
  localparam logic [2:0] S_SPLIT = 3'd5;
  localparam logic [2:0] S_YEAR  = 3'd6;
  localparam logic [2:0] S_MON   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       done_q, done_d;
  logic       out_valid_q, out_valid_d;

  logic [gdad_pkg::YearW-1:0]  y_q, y_d;
  logic [gdad_pkg::YearW-1:0]  rw_q, rw_d;
  logic [gdad_pkg::OffW-1:0]   r400_q, r400_d;
  logic [gdad_pkg::DayW-1:0]   d_q, d_d;
  logic [gdad_pkg::MonthW-1:0] m_q, m_d;
  logic [gdad_pkg::MonthW-1:0] i_q, i_d;
  logic [gdad_pkg::OffW-1:0]   off_q, off_d;
  logic [gdad_pkg::OffW-1:0]   rem_q, rem_d;
  logic [gdad_pkg::CountW-1:0] num_q, num_d;
  logic                        ovf_q, ovf_d;

  logic [gdad_pkg::DayW-1:0]   end_day_q, end_day_d;
  logic [gdad_pkg::MonthW-1:0] end_month_q, end_month_d;
  logic [gdad_pkg::YearW-1:0]  end_year_q, end_year_d;
  logic                        end_ovf_q, end_ovf_d;

  gdad_pkg::alu_op_e           alu_op;
  logic [gdad_pkg::CountW-1:0] alu_a, alu_b, alu_res;
  logic                        alu_borrow, alu_zero;

  logic                        leap;
  logic [gdad_pkg::OffW-1:0]   ylen;
  logic [gdad_pkg::DayW-1:0]   mlen_cur;
  logic [gdad_pkg::DayW-1:0]   mlen_start;
  logic [gdad_pkg::YearW-1:0]  y_inc;
  logic [gdad_pkg::OffW-1:0]   r400_inc;
  logic                        in_fire;
  logic                        out_fire;

  assign leap       = gdad_pkg::is_leap(y_q[1:0], r400_q);
  assign ylen       = gdad_pkg::year_len(leap);
  assign mlen_cur   = gdad_pkg::month_len(i_q, leap);
  assign mlen_start = gdad_pkg::month_len(m_q, leap);
  assign y_inc      = y_q + 14'd1;
  assign r400_inc   = (r400_q == gdad_pkg::LEAP_CYCLE - 9'd1) ? '0 : r400_q + 9'd1;

  assign in_ready_o = (state_q == S_IDLE) && !done_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  gdad_alu u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow),
    .zero_o   (alu_zero)
  );

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    y_d         = y_q;
    rw_d        = rw_q;
    r400_d      = r400_q;
    d_d         = d_q;
    m_d         = m_q;
    i_d         = i_q;
    off_d       = off_q;
    rem_d       = rem_q;
    num_d       = num_q;
    ovf_d       = ovf_q;
    end_day_d   = end_day_q;
    end_month_d = end_month_q;
    end_year_d  = end_year_q;
    end_ovf_d   = end_ovf_q;
    alu_op      = gdad_pkg::ALU_SUB;
    alu_a       = '0;
    alu_b       = '0;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (done_q && (!out_valid_q || out_ready_i)) begin
          // Hand the finished word to the output register.
          done_d      = 1'b0;
          out_valid_d = 1'b1;
          end_day_d   = d_q;
          end_month_d = m_q;
          end_year_d  = y_q;
          end_ovf_d   = ovf_q;
        end else if (in_fire) begin
          if (start_year_i == '0) begin
            y_d = 14'd1;
          end else if (start_year_i > gdad_pkg::YEAR_MAX) begin
            y_d = gdad_pkg::YEAR_MAX;
          end else begin
            y_d = start_year_i;
          end
          rw_d = y_d;
          if (start_month_i == '0) begin
            m_d = 4'd1;
          end else if (start_month_i > gdad_pkg::MONTH_LAST) begin
            m_d = gdad_pkg::MONTH_LAST;
          end else begin
            m_d = start_month_i;
          end
          d_d     = (start_day_i == '0) ? 5'd1 : start_day_i;
          num_d   = days_to_add_i;
          ovf_d   = 1'b0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        alu_a = {2'b0, rw_q};
        alu_b = {7'b0, gdad_pkg::LEAP_CYCLE};
        if (!alu_borrow) begin
          rw_d = alu_res[gdad_pkg::YearW-1:0];
        end else begin
          r400_d  = rw_q[gdad_pkg::OffW-1:0];
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        // A day past the end of the month reads as its last day.
        alu_a = {11'b0, mlen_start};
        alu_b = {11'b0, d_q};
        off_d = alu_borrow ? {4'b0, mlen_start} : {4'b0, d_q};
        i_d   = 4'd1;
        state_d = S_DOY;
      end
      S_DOY: begin
        alu_op = gdad_pkg::ALU_ADD;
        alu_a  = {7'b0, off_q};
        alu_b  = {11'b0, mlen_cur};
        if (i_q < m_q) begin
          off_d = alu_res[gdad_pkg::OffW-1:0];
          i_d   = i_q + 4'd1;
        end else begin
          state_d = S_REM;
        end
      end
      S_REM: begin
        alu_a   = {7'b0, ylen};
        alu_b   = {7'b0, off_q};
        rem_d   = alu_res[gdad_pkg::OffW-1:0];
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        // Entry to the split step marks "not yet compared" with a nonzero i.
        if (i_q == '0) begin
          // Count fits in the start year: add it to the day of the year.
          alu_op  = gdad_pkg::ALU_ADD;
          alu_a   = {7'b0, off_q};
          alu_b   = num_q;
          off_d   = alu_res[gdad_pkg::OffW-1:0];
          i_d     = 4'd1;
          state_d = S_MON;
        end else begin
          alu_a = num_q;
          alu_b = {7'b0, rem_q};
          if (alu_borrow || alu_zero) begin
            i_d = '0;
          end else begin
            num_d   = alu_res;
            y_d     = y_inc;
            r400_d  = r400_inc;
            state_d = S_YEAR;
          end
        end
      end
      S_YEAR: begin
        alu_a = num_q;
        alu_b = {7'b0, ylen};
        if (!alu_borrow && !alu_zero) begin
          num_d  = alu_res;
          y_d    = y_inc;
          r400_d = r400_inc;
        end else if (y_q > gdad_pkg::YEAR_MAX) begin
          ovf_d   = 1'b1;
          d_d     = gdad_pkg::DAY_LAST;
          m_d     = gdad_pkg::MONTH_LAST;
          y_d     = gdad_pkg::YEAR_MAX;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          off_d   = num_q[gdad_pkg::OffW-1:0];
          i_d     = 4'd1;
          state_d = S_MON;
        end
      end
      S_MON: begin
        alu_a = {7'b0, off_q};
        alu_b = {11'b0, mlen_cur};
        if ((i_q < gdad_pkg::MONTH_LAST) && !alu_borrow && !alu_zero) begin
          off_d = alu_res[gdad_pkg::OffW-1:0];
          i_d   = i_q + 4'd1;
        end else begin
          d_d     = off_q[gdad_pkg::DayW-1:0];
          m_d     = i_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q         <= y_d;
    rw_q        <= rw_d;
    r400_q      <= r400_d;
    d_q         <= d_d;
    m_q         <= m_d;
    i_q         <= i_d;
    off_q       <= off_d;
    rem_q       <= rem_d;
    num_q       <= num_d;
    ovf_q       <= ovf_d;
    end_day_q   <= end_day_d;
    end_month_q <= end_month_d;
    end_year_q  <= end_year_d;
    end_ovf_q   <= end_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign end_day_o       = end_day_q;
  assign end_month_o     = end_month_q;
  assign end_year_o      = end_year_q;
  assign year_overflow_o = end_ovf_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("unit still ready right after taking a word");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (end_month_o >= 4'd1) && (end_month_o <= gdad_pkg::MONTH_LAST))
    else $error("result month out of range");

  a_overflow_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && year_overflow_o |->
      (end_year_o == gdad_pkg::YEAR_MAX) && (end_day_o == gdad_pkg::DAY_LAST))
    else $error("overflow result not saturated");

  a_normal_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !year_overflow_o |->
      (end_year_o <= gdad_pkg::YEAR_MAX) && (end_year_o != '0) && (end_day_o != '0))
    else $error("result date out of range");

endmodule

### verif/gregorian_date_add_days_unit_tb.sv
`timescale 1ns / 1ps

module gregorian_date_add_days_unit_tb;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainWait  = 300;
  localparam int unsigned LastYear   = 9999;

  typedef struct packed {
    logic [gdad_pkg::DayW-1:0]   day;
    logic [gdad_pkg::MonthW-1:0] month;
    logic [gdad_pkg::YearW-1:0]  year;
    logic                        ovf;
  } date_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid;
  logic                          in_ready_o;
  logic [gdad_pkg::DayW-1:0]     start_day;
  logic [gdad_pkg::MonthW-1:0]   start_month;
  logic [gdad_pkg::YearW-1:0]    start_year;
  logic [gdad_pkg::CountW-1:0]   days_to_add;
  logic                          out_valid_o;
  logic                          out_ready;
  logic [gdad_pkg::DayW-1:0]     end_day_o;
  logic [gdad_pkg::MonthW-1:0]   end_month_o;
  logic [gdad_pkg::YearW-1:0]    end_year_o;
  logic                          year_overflow_o;

  date_t       pending_dates[$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  bit          idle_on;
  int unsigned hold_req;

  gregorian_date_add_days_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .start_day_i    (start_day),
    .start_month_i  (start_month),
    .start_year_i   (start_year),
    .days_to_add_i  (days_to_add),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .end_day_o      (end_day_o),
    .end_month_o    (end_month_o),
    .end_year_o     (end_year_o),
    .year_overflow_o(year_overflow_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Date arithmetic used to predict each result.
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_year(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    int unsigned n;
    case (m)
      2:             n = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic date_t predict_date(input logic [gdad_pkg::DayW-1:0] d_in,
                                         input logic [gdad_pkg::MonthW-1:0] m_in,
                                         input logic [gdad_pkg::YearW-1:0] y_in,
                                         input logic [gdad_pkg::CountW-1:0] n_in);
    int unsigned d, m, y, num, off, rem, em;
    date_t res;
    d   = d_in;
    m   = m_in;
    y   = y_in;
    num = n_in;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (y < 1) y = 1;
    if (y > LastYear) y = LastYear;
    if (d < 1) d = 1;
    if (d > days_in_month(m, y)) d = days_in_month(m, y);

    off = d;
    for (int unsigned i = 1; i < m; i++) off += days_in_month(i, y);

    rem = days_in_year(y) - off;
    if (num <= rem) begin
      off += num;
    end else begin
      num -= rem;
      y++;
      while (num > days_in_year(y)) begin
        num -= days_in_year(y);
        y++;
      end
      off = num;
    end

    if (y > LastYear) begin
      res.day   = gdad_pkg::DAY_LAST;
      res.month = gdad_pkg::MONTH_LAST;
      res.year  = gdad_pkg::YEAR_MAX;
      res.ovf   = 1'b1;
    end else begin
      em = 1;
      while (em < 12 && off > days_in_month(em, y)) begin
        off -= days_in_month(em, y);
        em++;
      end
      res.day   = off[gdad_pkg::DayW-1:0];
      res.month = em[gdad_pkg::MonthW-1:0];
      res.year  = y[gdad_pkg::YearW-1:0];
      res.ovf   = 1'b0;
    end
    return res;
  endfunction

  // Offers one word and records its expected result once it is taken.
  task automatic send_date(input logic [gdad_pkg::DayW-1:0] d,
                           input logic [gdad_pkg::MonthW-1:0] m,
                           input logic [gdad_pkg::YearW-1:0] y,
                           input logic [gdad_pkg::CountW-1:0] n);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    start_day   <= d;
    start_month <= m;
    start_year  <= y;
    days_to_add <= n;
    do @(posedge clk_i); while (!in_ready_o);
    pending_dates.push_back(predict_date(d, m, y, n));
  endtask

  // Mostly legal dates with a spread of counts; some raw bit patterns and
  // some dates close to the top year so that overflow shows up.
  task automatic send_random_date();
    int unsigned kind, sel, d, m, y, n;
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      d = $urandom;
      m = $urandom;
      y = $urandom;
    end else begin
      y = (kind == 9) ? $urandom_range(9800, LastYear) : $urandom_range(1, LastYear);
      m = $urandom_range(1, 12);
      d = ($urandom_range(0, 5) == 0) ? days_in_month(m, y)
                                      : $urandom_range(1, days_in_month(m, y));
    end
    sel = $urandom_range(0, 3);
    case (sel)
      0:       n = $urandom_range(0, 400);
      1:       n = $urandom_range(0, 3000);
      default: n = $urandom;
    endcase
    send_date(d[gdad_pkg::DayW-1:0], m[gdad_pkg::MonthW-1:0], y[gdad_pkg::YearW-1:0],
              n[gdad_pkg::CountW-1:0]);
  endtask

  task automatic wait_all_results();
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_date(5'd1, 4'd1, 14'd1, 16'd0);
    send_date(5'd31, 4'd12, 14'd9999, 16'd0);
    send_date(5'd1, 4'd1, 14'd1, 16'hFFFF);
    send_date(5'd31, 4'd12, 14'd9998, 16'd1);
    // A count that lands exactly on the last day of the next year.
    send_date(5'd31, 4'd12, 14'd2000, 16'd365);
    send_date(5'd1, 4'd1, 14'd2001, 16'd364);
  endtask

  task automatic test_clamping();
    send_date(5'd0, 4'd3, 14'd1999, 16'd10);
    send_date(5'd15, 4'd0, 14'd1999, 16'd10);
    send_date(5'd15, 4'd15, 14'd1999, 16'd10);
    send_date(5'd10, 4'd6, 14'd0, 16'd100);
    send_date(5'd10, 4'd6, 14'h3FFF, 16'd0);
    send_date(5'd31, 4'd2, 14'd2000, 16'd0);
    send_date(5'd31, 4'd2, 14'd1900, 16'd0);
    send_date(5'd31, 4'd4, 14'd2023, 16'd1);
  endtask

  task automatic test_leap_rules();
    send_date(5'd28, 4'd2, 14'd2000, 16'd1);
    send_date(5'd28, 4'd2, 14'd1900, 16'd1);
    send_date(5'd28, 4'd2, 14'd2004, 16'd1);
    send_date(5'd28, 4'd2, 14'd2100, 16'd1);
    send_date(5'd1, 4'd1, 14'd1600, 16'd1461);
  endtask

  task automatic test_overflow();
    send_date(5'd31, 4'd12, 14'd9999, 16'd1);
    send_date(5'd1, 4'd1, 14'd9999, 16'hFFFF);
    send_date(5'd1, 4'd1, 14'd9820, 16'hFFFF);
  endtask

  // The receiver stops for a long stretch while words keep coming.
  task automatic test_backpressure();
    hold_req = 400;
    for (int i = 0; i < 20; i++) send_random_date();
  endtask

  // The sender waits for every result before going on.
  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_random_date();
    in_valid <= 1'b0;
    wait_all_results();
    for (int i = 0; i < 10; i++) send_random_date();
  endtask

  task automatic test_random(input int unsigned count, input bit with_idle);
    idle_on = with_idle;
    for (int unsigned i = 0; i < count; i++) send_random_date();
    idle_on = 1'b1;
  endtask

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    date_t exp;
    if (out_valid_o && out_ready) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result word: %0d-%0d-%0d ovf %0b", end_year_o, end_month_o,
               end_day_o, year_overflow_o);
        fail_cnt++;
      end else begin
        exp = pending_dates.pop_front();
        if (end_day_o !== exp.day) begin
          $error("end_day: expected %0d, got %0d", exp.day, end_day_o);
          fail_cnt++;
        end
        if (end_month_o !== exp.month) begin
          $error("end_month: expected %0d, got %0d", exp.month, end_month_o);
          fail_cnt++;
        end
        if (end_year_o !== exp.year) begin
          $error("end_year: expected %0d, got %0d", exp.year, end_year_o);
          fail_cnt++;
        end
        if (year_overflow_o !== exp.ovf) begin
          $error("year_overflow: expected %0b, got %0b", exp.ovf, year_overflow_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    fail_cnt    = 0;
    cycle_cnt   = 0;
    idle_on     = 1'b1;
    hold_req    = 0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    start_day   = '0;
    start_month = '0;
    start_year  = '0;
    days_to_add = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_clamping();
    test_leap_rules();
    test_overflow();
    test_backpressure();
    test_drain_pause();
    test_random(600, 1'b1);
    test_random(200, 1'b0);
    test_random(610, 1'b1);

    in_valid <= 1'b0;
    wait_all_results();
    repeat (DrainWait) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
